### sv/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

  // Internal Q2.14 component width
  localparam int Q_W      = 16;
  // Rotation-matrix terms, 30 fractional bits
  localparam int R_W      = 36;
  // CORDIC vector width, room for gain growth
  localparam int CX_W     = 42;
  // CORDIC angle width, 30 fractional bits
  localparam int Z_W      = 34;
  localparam int ANG_FRAC = 30;
  localparam int THR_W    = 31;
  // Square-root radicand and partial-root width
  localparam int RAD_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int TAB_LEN  = 30;

  localparam logic [THR_W-1:0] THR_RESET = 31'd1073740750;
  localparam logic signed [Z_W-1:0] PI_ANG  = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI = 34'sd1686629713;

  // atan(2^-i), 30 fractional bits, rounded to nearest
  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2
  };

  // One classified item waiting for the angle units
  typedef struct packed {
    logic                   gim;
    logic                   r31_pos;
    logic signed [R_W-1:0]  roll_y;
    logic signed [R_W-1:0]  roll_x;
    logic signed [R_W:0]    pitch_y;
    logic signed [CX_W-1:0] yaw_y;
    logic signed [CX_W-1:0] yaw_x;
    logic [RAD_W-1:0]       rad;
  } qte_job_t;

  // Transfer from the front end into the queue
  typedef struct packed {
    logic     valid;
    qte_job_t job;
  } qte_push_t;

endpackage

### sv/qte_in_if.sv
`timescale 1ns / 1ps
interface qte_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] q_w;
  logic signed [DATA_WIDTH-1:0] q_x;
  logic signed [DATA_WIDTH-1:0] q_y;
  logic signed [DATA_WIDTH-1:0] q_z;

  modport source (output valid, q_w, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_w, q_x, q_y, q_z, output ready);
endinterface

### sv/qte_out_if.sv
`timescale 1ns / 1ps
interface qte_out_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] roll;
  logic signed [DATA_WIDTH-1:0] pitch;
  logic signed [DATA_WIDTH-1:0] yaw;
  logic                         gimbal_lock;

  modport source (output valid, roll, pitch, yaw, gimbal_lock, input ready);
  modport sink (input valid, roll, pitch, yaw, gimbal_lock, output ready);
endinterface

### sv/qte_front.sv
`timescale 1ns / 1ps
module qte_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] in_q_w,
  input  logic signed [DATA_WIDTH-1:0] in_q_x,
  input  logic signed [DATA_WIDTH-1:0] in_q_y,
  input  logic signed [DATA_WIDTH-1:0] in_q_z,
  input  logic [qte_pkg::THR_W-1:0]    thr,
  output qte_pkg::qte_push_t           push
);
  import qte_pkg::*;

  logic [DATA_WIDTH-1:0]  raw [4];
  logic signed [Q_W-1:0]  q_l [4];
  logic signed [Q_W-1:0]  q_r [4];
  logic signed [2*Q_W-1:0] p_r [10];
  logic                   v1_r, v2_r, v3_r, v4_r, v5_r;

  assign raw[0] = in_q_w;
  assign raw[1] = in_q_x;
  assign raw[2] = in_q_y;
  assign raw[3] = in_q_z;

  // Bring each component to Q2.14: floor extra bits or pad with zeros
  for (genvar k = 0; k < 4; k++) begin : g_load
    if (DATA_WIDTH >= Q_W) begin : g_cut
      assign q_l[k] = raw[k][DATA_WIDTH-1 -: Q_W];
    end else begin : g_pad
      assign q_l[k] = {raw[k], {(Q_W-DATA_WIDTH){1'b0}}};
    end
  end

  // Advance the valid bits of all stages together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Capture the transfer
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) q_r[k] <= q_l[k];
    end
  end

  // Component products: ww xx yy zz xy wz xz wy yz wx
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= q_r[0] * q_r[0];
      p_r[1] <= q_r[1] * q_r[1];
      p_r[2] <= q_r[2] * q_r[2];
      p_r[3] <= q_r[3] * q_r[3];
      p_r[4] <= q_r[1] * q_r[2];
      p_r[5] <= q_r[0] * q_r[3];
      p_r[6] <= q_r[1] * q_r[3];
      p_r[7] <= q_r[0] * q_r[2];
      p_r[8] <= q_r[2] * q_r[3];
      p_r[9] <= q_r[0] * q_r[1];
    end
  end

  // Rotation-matrix terms with 30 fractional bits
  logic signed [R_W-1:0] r11_r, r21_r, r31_r, r32_r, r33_r, r12_r, r13_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r11_r <= (R_W'(p_r[0]) + R_W'(p_r[1]) - R_W'(p_r[2]) - R_W'(p_r[3])) <<< 2;
      r33_r <= (R_W'(p_r[0]) - R_W'(p_r[1]) - R_W'(p_r[2]) + R_W'(p_r[3])) <<< 2;
      r21_r <= (R_W'(p_r[4]) + R_W'(p_r[5])) <<< 3;
      r12_r <= (R_W'(p_r[4]) - R_W'(p_r[5])) <<< 3;
      r31_r <= (R_W'(p_r[6]) - R_W'(p_r[7])) <<< 3;
      r13_r <= (R_W'(p_r[6]) + R_W'(p_r[7])) <<< 3;
      r32_r <= (R_W'(p_r[8]) + R_W'(p_r[9])) <<< 3;
    end
  end

  // Classify against the threshold; split r31*r13 into two partial products
  logic [R_W-1:0]          mag;
  logic signed [R_W-16:0]  a_s;
  logic signed [R_W-19:0]  hi_s;
  logic signed [18:0]      lo_s;
  assign mag  = r31_r[R_W-1] ? R_W'(-r31_r) : R_W'(r31_r);
  assign a_s  = r31_r[R_W-1:15];
  assign hi_s = r13_r[R_W-1:18];
  assign lo_s = $signed({1'b0, r13_r[17:0]});

  logic                        gim_r, small_r, pos_r;
  logic [2*ANG_FRAC-1:0]       sq_r;
  logic signed [2*R_W-34:0]    ph_r;
  logic signed [R_W+4:0]       pl_r;
  logic signed [R_W-1:0]       r11_d_r, r21_d_r, r31_d_r, r32_d_r, r33_d_r, r12_d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      gim_r   <= mag > R_W'(thr);
      small_r <= mag[R_W-1:ANG_FRAC] == '0;
      pos_r   <= (r31_r > 0);
      sq_r    <= mag[ANG_FRAC-1:0] * mag[ANG_FRAC-1:0];
      ph_r    <= a_s * hi_s;
      pl_r    <= a_s * lo_s;
      r11_d_r <= r11_r;
      r21_d_r <= r21_r;
      r31_d_r <= r31_r;
      r32_d_r <= r32_r;
      r33_d_r <= r33_r;
      r12_d_r <= r12_r;
    end
  end

  // Assemble the job for the angle units
  localparam int PW = 2*R_W - 15;
  logic signed [PW-1:0]   prod_full;
  logic signed [CX_W-1:0] prod;
  qte_job_t               job_nxt, job_r;
  assign prod_full = (PW'(ph_r) <<< 18) + PW'(pl_r);
  assign prod      = prod_full[CX_W+14:15];

  always_comb begin
    job_nxt.gim     = gim_r;
    job_nxt.r31_pos = pos_r;
    job_nxt.roll_y  = r32_d_r;
    job_nxt.roll_x  = r33_d_r;
    job_nxt.pitch_y = -(R_W+1)'(r31_d_r);
    if (gim_r) begin
      job_nxt.yaw_y = -CX_W'(r12_d_r);
      job_nxt.yaw_x = -prod;
    end else begin
      job_nxt.yaw_y = CX_W'(r21_d_r);
      job_nxt.yaw_x = CX_W'(r11_d_r);
    end
    job_nxt.rad = small_r ? ((RAD_W'(1) << (2*ANG_FRAC)) - RAD_W'(sq_r)) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) job_r <= job_nxt;
  end

  assign push.valid = v5_r;
  assign push.job   = job_r;

endmodule

### sv/qte_fifo.sv
`timescale 1ns / 1ps
module qte_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  qte_pkg::qte_push_t push,
  input  logic               pop,
  output logic               full,
  output logic               empty,
  output qte_pkg::qte_job_t  head
);
  import qte_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  qte_job_t          mem [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [AW:0]       cnt_r;
  logic              wr_en;

  assign full  = cnt_r == (AW+1)'(DEPTH);
  assign empty = cnt_r == '0;
  assign wr_en = push.valid && !full;
  assign head  = mem[rd_r];

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_r] <= push.job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wr_r <= wr_r + AW'(1);
      if (pop) rd_r <= rd_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(pop);
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && full) |=> (push.valid && $stable(push.job)))
    else $error("front item lost while queue full");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !wr_en) |=> cnt_r == $past(cnt_r) - (AW+1)'(1))
    else $error("queue occupancy lost track");

endmodule

### sv/qte_cordic.sv
`timescale 1ns / 1ps
module qte_cordic #(
  parameter int STEPS = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qte_pkg::CX_W-1:0] y_i,
  input  logic signed [qte_pkg::CX_W-1:0] x_i,
  output logic signed [qte_pkg::Z_W-1:0]  z_o
);
  import qte_pkg::*;

  logic signed [CX_W-1:0] x_r [STEPS+1];
  logic signed [CX_W-1:0] y_r [STEPS+1];
  logic signed [Z_W-1:0]  z_r [STEPS+1];

  // Fold the left half-plane by rotating through pi
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_i < 0) begin
        x_r[0] <= -x_i;
        y_r[0] <= -y_i;
        z_r[0] <= (y_i >= 0) ? PI_ANG : -PI_ANG;
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        z_r[0] <= '0;
      end
    end
  end

  // One vectoring micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[i]);
    logic signed [CX_W-1:0] dx, dy;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        priority if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + ANG;
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - ANG;
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign z_o = z_r[STEPS];

endmodule

### sv/qte_back.sv
`timescale 1ns / 1ps
module qte_back #(
  parameter int DATA_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  qte_pkg::qte_job_t head,
  output logic              pop,
  qte_out_if.source         out_ch
);
  import qte_pkg::*;

  localparam int SQ = ROOT_W;
  localparam int SH = ANG_FRAC - (DATA_WIDTH - 3);

  logic en;
  logic out_valid_r;

  // The whole back pipeline moves when the output register is empty or being taken
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && head_valid;

  // Square root of the radicand, one root bit per stage
  logic             v_r   [SQ+1];
  qte_job_t         job_r [SQ+1];
  logic [RAD_W-1:0] rem_r [SQ+1];
  logic [RAD_W-1:0] res_r [SQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      job_r[0] <= head;
      rem_r[0] <= head.rad;
      res_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= SQ; k++) begin : g_sqrt
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2*(SQ-k));
    logic [RAD_W-1:0] trial;
    assign trial = res_r[k-1] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        job_r[k] <= job_r[k-1];
        if (rem_r[k-1] >= trial) begin
          rem_r[k] <= rem_r[k-1] - trial;
          res_r[k] <= (res_r[k-1] >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_r[k-1];
          res_r[k] <= res_r[k-1] >> 1;
        end
      end
    end
  end

  // Three angle lanes side by side
  qte_job_t               jq;
  logic signed [Z_W-1:0]  z_roll, z_pitch, z_yaw;
  assign jq = job_r[SQ];

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
    .clk (clk), .en (en),
    .y_i (CX_W'(jq.roll_y)), .x_i (CX_W'(jq.roll_x)), .z_o (z_roll)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
    .clk (clk), .en (en),
    .y_i (CX_W'(jq.pitch_y)),
    .x_i ($signed(CX_W'(res_r[SQ][ROOT_W-1:0]))),
    .z_o (z_pitch)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
    .clk (clk), .en (en),
    .y_i (jq.yaw_y), .x_i (jq.yaw_x), .z_o (z_yaw)
  );

  // Carry the branch flags alongside the lanes
  logic c_v_r   [CORDIC_STEPS+1];
  logic c_gim_r [CORDIC_STEPS+1];
  logic c_pos_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c_gim_r[0] <= jq.gim;
      c_pos_r[0] <= jq.r31_pos;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        c_gim_r[i+1] <= c_gim_r[i];
        c_pos_r[i+1] <= c_pos_r[i];
      end
    end
  end

  // Valid bits of every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= SQ; k++) v_r[k] <= 1'b0;
      for (int i = 0; i <= CORDIC_STEPS; i++) c_v_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= pop;
      for (int k = 1; k <= SQ; k++) v_r[k] <= v_r[k-1];
      c_v_r[0] <= v_r[SQ];
      for (int i = 0; i < CORDIC_STEPS; i++) c_v_r[i+1] <= c_v_r[i];
      out_valid_r <= c_v_r[CORDIC_STEPS];
    end
  end

  // Round half up into the output format
  function automatic logic [DATA_WIDTH-1:0] to_out(input logic signed [Z_W-1:0] ang);
    logic signed [Z_W:0] t;
    t = $signed({ang[Z_W-1], ang}) + $signed((Z_W+1)'(1) << (SH-1));
    t = t >>> SH;
    return t[DATA_WIDTH-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] roll_r, pitch_r, yaw_r;
  logic                  gim_out_r;

  // Select branch results into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      gim_out_r <= c_gim_r[CORDIC_STEPS];
      yaw_r     <= to_out(z_yaw);
      if (c_gim_r[CORDIC_STEPS]) begin
        roll_r  <= '0;
        pitch_r <= to_out(c_pos_r[CORDIC_STEPS] ? -HALF_PI : HALF_PI);
      end else begin
        roll_r  <= to_out(z_roll);
        pitch_r <= to_out(z_pitch);
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.roll        = roll_r;
  assign out_ch.pitch       = pitch_r;
  assign out_ch.yaw         = yaw_r;
  assign out_ch.gimbal_lock = gim_out_r;

endmodule

### sv/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// Quaternion (w, x, y, z, signed Q2.14) to ZYX Euler angles (roll, pitch,
// yaw, signed Q3.13 radians) with a gimbal-lock flag.
// in_ch: valid/ready channel, one quaternion per transfer.
// out_ch: valid/ready channel, exactly one result per input, in order.
// cfg_we/cfg_wdata: writes the 31-bit gimbal threshold on |r31|; write it
// only while no item is in flight.
// Throughput: one item per cycle while out_ch.ready stays high. Between
// the accepting edge and out_ch.valid lie the capture plus 4 more front
// stages (products, matrix terms, classification, job), the queue write,
// 32 stages of the bit-per-stage square root, CORDIC_STEPS + 1 CORDIC
// stages and the output register.
// Reset clears all valid bits and the queue and loads the threshold with
// about 0.999999. When out_ch.ready is low and the output register holds
// a result, the back pipeline holds; the four-entry queue keeps taking
// front results until it fills, then in_ch.ready drops.
module quaternion_to_euler_angles #(
  parameter int DATA_WIDTH   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  qte_in_if.sink                    in_ch,
  qte_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [qte_pkg::THR_W-1:0] cfg_wdata
);
  import qte_pkg::*;

  logic [THR_W-1:0] thr_r;
  qte_push_t        push;
  qte_job_t         head;
  logic             full, empty, pop, en_f;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  assign en_f        = !full;
  assign in_ch.ready = en_f;

  qte_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en_f),
    .in_valid (in_ch.valid),
    .in_q_w   (in_ch.q_w),
    .in_q_x   (in_ch.q_x),
    .in_q_y   (in_ch.q_y),
    .in_q_z   (in_ch.q_z),
    .thr      (thr_r),
    .push     (push)
  );

  qte_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (full),
    .empty (empty),
    .head  (head)
  );

  qte_back #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!empty),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
